@@ rtl/core/acia_pkg.sv @@
package acia_pkg;

  localparam int unsigned PeriodW = 20;
  localparam int unsigned CountW  = 21;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PeriodW-1:0] PeriodReset  = 20'd1042;
  localparam logic [1:0]         IrqKindReset = 2'd1;
  localparam logic [1:0]         IrqNone      = 2'd3;

  localparam logic [7:0] StatusReset = 8'h02;
  localparam logic [7:0] StatRdrf    = 8'h01;
  localparam logic [7:0] StatTdre    = 8'h02;
  localparam logic [7:0] StatIrq     = 8'h80;
  localparam logic [7:0] ClrRxMask   = 8'h7e;
  localparam logic [7:0] ClrTxMask   = 8'h7d;
  localparam logic [7:0] CtrlRxIe    = 8'h80;
  localparam logic [7:0] CtrlTxMask  = 8'h60;
  localparam logic [7:0] CtrlTxIe    = 8'h20;

  localparam logic [CfgIdxW-1:0] CfgCharPeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIrqKind    = 2'd1;

  localparam logic SelCtrl = 1'b0;
  localparam logic SelData = 1'b1;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_offered;
    logic [7:0] elapsed_cycles;
    logic [7:0] write_data;
    logic       reg_sel;
    logic [1:0] func;
  } item_t;

  typedef struct packed {
    logic [1:0] irq_line;
    logic       irq_request;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       rx_taken;
    logic [7:0] status_now;
    logic [7:0] read_data;
  } result_t;

endpackage

@@ rtl/core/acia_in_stage.sv @@
module acia_in_stage import acia_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        take_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign s_axis_tready = !valid_q || take_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d               = 1'b1;
      item_d.func           = s_axis_tuser;
      item_d.reg_sel        = s_axis_tdata[0];
      item_d.write_data     = s_axis_tdata[8:1];
      item_d.elapsed_cycles = s_axis_tdata[16:9];
      item_d.rx_offered     = s_axis_tdata[17];
      item_d.rx_byte        = s_axis_tdata[25:18];
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/core/acia_core.sv @@
module acia_core import acia_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PeriodW-1:0] cfg_data_i,
  input  logic               step_i,
  input  item_t              item_i,
  output result_t            result_o
);

  logic [PeriodW-1:0] period_q, period_d;
  logic [1:0]         irq_kind_q, irq_kind_d;
  logic [7:0]         ctrl_q, ctrl_d;
  logic [7:0]         status_q, status_d;
  logic [7:0]         tx_data_q, tx_data_d;
  logic [7:0]         rx_data_q, rx_data_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [CountW-1:0]  elapsed_ext;
  logic               irq;

  assign elapsed_ext = {{(CountW-8){1'b0}}, item_i.elapsed_cycles};

  // configuration writes
  always_comb begin
    period_d   = period_q;
    irq_kind_d = irq_kind_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCharPeriod: period_d   = cfg_data_i;
        CfgIrqKind:    irq_kind_d = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // one step of the serial port
  always_comb begin
    ctrl_d    = ctrl_q;
    status_d  = status_q;
    tx_data_d = tx_data_q;
    rx_data_d = rx_data_q;
    count_d   = count_q;
    irq       = 1'b0;
    result_o  = '0;
    case (func_e'(item_i.func))
      FUNC_READ: begin
        if (item_i.reg_sel == SelCtrl) begin
          result_o.read_data = status_q;
        end else begin
          result_o.read_data = rx_data_q;
          status_d           = status_q & ClrRxMask;
        end
      end
      FUNC_WRITE: begin
        if (item_i.reg_sel == SelCtrl) begin
          ctrl_d = item_i.write_data;
        end else begin
          tx_data_d = item_i.write_data;
          status_d  = status_q & ClrTxMask;
        end
      end
      FUNC_TICK: begin
        if (elapsed_ext < count_q) begin
          count_d = count_q - elapsed_ext;
        end else begin
          count_d = {1'b0, period_q};
          if (item_i.rx_offered) begin
            rx_data_d          = item_i.rx_byte;
            status_d           = status_d | StatRdrf;
            result_o.rx_taken  = 1'b1;
            if ((ctrl_q & CtrlRxIe) != 8'h00) begin
              status_d = status_d | StatIrq;
              irq      = 1'b1;
            end
          end
          if ((status_q & StatTdre) == 8'h00) begin
            result_o.tx_valid = 1'b1;
            result_o.tx_byte  = tx_data_q;
            status_d          = status_d | StatTdre;
            if ((ctrl_q & CtrlTxMask) == CtrlTxIe) begin
              status_d = status_d | StatIrq;
              irq      = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    result_o.status_now  = status_d;
    result_o.irq_request = irq && (irq_kind_q != IrqNone);
    result_o.irq_line    = irq_kind_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PeriodReset;
      irq_kind_q <= IrqKindReset;
      ctrl_q     <= '0;
      status_q   <= StatusReset;
      tx_data_q  <= '0;
      rx_data_q  <= '0;
      count_q    <= '0;
    end else begin
      period_q   <= period_d;
      irq_kind_q <= irq_kind_d;
      if (step_i) begin
        ctrl_q    <= ctrl_d;
        status_q  <= status_d;
        tx_data_q <= tx_data_d;
        rx_data_q <= rx_data_d;
        count_q   <= count_d;
      end
    end
  end

endmodule

@@ rtl/core/acia_serial_port_model.sv @@
// channel  | handshake                   | payload
// ---------+-----------------------------+------------------------------------------
// request  | s_axis_tvalid/s_axis_tready | s_axis_tdata, s_axis_tuser (item kind)
// result   | m_axis_tvalid/m_axis_tready | m_axis_tdata
// config   | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one request per cycle while the result channel is not stalled; results are registered
// path: input register, one step of port logic, result register
// reset clears status to transmitter empty, period 1042, irq line 1, countdown zero
// a stalled result holds its register; the input register keeps taking requests
// until it is full as well
module acia_serial_port_model import acia_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // reg_sel[0], write_data[8:1], elapsed_cycles[16:9], rx_offered[17], rx_byte[25:18]
  input  logic [31:0]        s_axis_tdata,
  // func[1:0]
  input  logic [1:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // read_data[7:0], status_now[15:8], rx_taken[16], tx_valid[17], tx_byte[25:18],
  // irq_request[26], irq_line[28:27]
  output logic [31:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PeriodW-1:0] cfg_data_i
);

  logic    in_valid;
  item_t   item;
  logic    out_free;
  logic    step;
  result_t result;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  assign out_free = !out_valid_q || m_axis_tready;
  assign step     = in_valid && out_free;

  acia_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (out_free),
    .valid_o       (in_valid),
    .item_o        (item)
  );

  acia_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .item_i      (item),
    .result_o    (result)
  );

  assign cfg_ready_o = 1'b1;

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

endmodule

@@ tb/acia_port_checker.sv @@
module acia_port_checker import acia_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_ready_i,
  input  logic [31:0]        req_data_i,
  input  logic [1:0]         req_kind_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [31:0]        res_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PeriodW-1:0] cfg_data_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o
);

  logic [PeriodW-1:0] period_q;
  logic [1:0]         line_q;
  logic [7:0]         ctrl_q;
  logic [7:0]         status_q;
  logic [7:0]         tx_hold_q;
  logic [7:0]         rx_hold_q;
  logic [CountW-1:0]  countdown_q;
  result_t            awaited_results[$];
  result_t            want_res;
  result_t            got_res;
  int unsigned        errs = 0;

  function automatic result_t port_response(item_t req);
    result_t res;
    logic    irq;
    res = '0;
    irq = 1'b0;
    res.irq_line = line_q;
    case (req.func)
      FUNC_READ: begin
        if (req.reg_sel == SelCtrl) begin
          res.read_data = status_q;
        end else begin
          res.read_data = rx_hold_q;
          status_q = status_q & ClrRxMask;
        end
      end
      FUNC_WRITE: begin
        if (req.reg_sel == SelCtrl) begin
          ctrl_q = req.write_data;
        end else begin
          tx_hold_q = req.write_data;
          status_q = status_q & ClrTxMask;
        end
      end
      FUNC_TICK: begin
        if (CountW'(req.elapsed_cycles) < countdown_q) begin
          countdown_q = countdown_q - CountW'(req.elapsed_cycles);
        end else begin
          // period ran out: reload, overshoot dropped, serve both directions
          countdown_q = CountW'(period_q);
          if (req.rx_offered) begin
            rx_hold_q = req.rx_byte;
            status_q = status_q | StatRdrf;
            res.rx_taken = 1'b1;
            if ((ctrl_q & CtrlRxIe) != '0) begin
              status_q = status_q | StatIrq;
              irq = 1'b1;
            end
          end
          if ((status_q & StatTdre) == '0) begin
            res.tx_valid = 1'b1;
            res.tx_byte = tx_hold_q;
            status_q = status_q | StatTdre;
            if ((ctrl_q & CtrlTxMask) == CtrlTxIe) begin
              status_q = status_q | StatIrq;
              irq = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    res.status_now = status_q;
    res.irq_request = irq && (line_q != IrqNone);
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %02h, actual %02h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q = PeriodReset;
      line_q = IrqKindReset;
      ctrl_q = '0;
      status_q = StatusReset;
      tx_hold_q = '0;
      rx_hold_q = '0;
      countdown_q = '0;
      awaited_results.delete();
      mismatches_o <= errs;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgCharPeriod: period_q = cfg_data_i;
          CfgIrqKind:    line_q = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        got_res = result_t'(res_data_i[$bits(result_t)-1:0]);
        if (awaited_results.size() == 0) begin
          $display("%0t: result %h expected none, actual arrived", $time, res_data_i);
          errs++;
        end else begin
          want_res = awaited_results.pop_front();
          check_field("read_data", want_res.read_data, got_res.read_data);
          check_field("status_now", want_res.status_now, got_res.status_now);
          check_field("rx_taken", 8'(want_res.rx_taken), 8'(got_res.rx_taken));
          check_field("tx_valid", 8'(want_res.tx_valid), 8'(got_res.tx_valid));
          check_field("tx_byte", want_res.tx_byte, got_res.tx_byte);
          check_field("irq_request", 8'(want_res.irq_request), 8'(got_res.irq_request));
          check_field("irq_line", 8'(want_res.irq_line), 8'(got_res.irq_line));
        end
      end
      if (req_valid_i && req_ready_i) begin
        awaited_results.push_back(
          port_response(item_t'({req_data_i[$bits(item_t)-3:0], req_kind_i})));
      end
      mismatches_o <= errs;
      pending_o <= awaited_results.size();
    end
  end

endmodule

@@ tb/tb_acia_serial_port_model.sv @@
module tb_acia_serial_port_model;
  import acia_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned LongHold  = 300;
  localparam logic [1:0]         FuncSpare   = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnlisted = 2'd2;
  localparam logic [PeriodW-1:0] PeriodMax   = 20'hfffff;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_PATTERN,
    SINK_SPARSE,
    SINK_COIN
  } sink_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;
  logic [1:0]         s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [31:0]        m_axis_tdata;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [PeriodW-1:0] cfg_data_i;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned holds_asked;
  int unsigned burst_left;

  acia_serial_port_model i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  acia_port_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_kind_i   (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic offer_request(logic [1:0] fn, logic sel, logic [7:0] wdata,
                               logic [7:0] elapsed, logic offered, logic [7:0] rbyte);
    item_t       req;
    int unsigned gap;
    req.func = fn;
    req.reg_sel = sel;
    req.write_data = wdata;
    req.elapsed_cycles = elapsed;
    req.rx_offered = offered;
    req.rx_byte = rbyte;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= 32'(req[$bits(item_t)-1:2]);
    s_axis_tuser <= req.func;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic offer_random_request();
    int unsigned pick;
    logic [7:0]  elapsed;
    logic [1:0]  fn;
    pick = $urandom_range(0, 99);
    elapsed = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    if (pick < 45) begin
      fn = FUNC_TICK;
    end else if (pick < 70) begin
      fn = FUNC_READ;
    end else if (pick < 95) begin
      fn = FUNC_WRITE;
    end else begin
      fn = FuncSpare;
    end
    offer_request(fn, 1'($urandom_range(0, 1)), 8'($urandom), elapsed,
                  1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [PeriodW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic program_port(logic [PeriodW-1:0] period, logic [1:0] kind,
                              logic touch_unlisted);
    write_reg(CfgCharPeriod, period);
    write_reg(CfgIrqKind, PeriodW'(kind));
    if (touch_unlisted) write_reg(CfgUnlisted, '1);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : sink
    sink_mode_e  mode;
    int unsigned span;
    int unsigned phase;
    int unsigned holds_done;
    int unsigned hold_left;
    logic [7:0]  pattern;
    m_axis_tready = 1'b0;
    mode = SINK_OPEN;
    span = 0;
    phase = 0;
    holds_done = 0;
    hold_left = 0;
    pattern = '1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && holds_asked > holds_done) begin
        holds_done++;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          span = $urandom_range(20, 80);
          pattern = 8'($urandom);
        end
        span--;
        phase++;
        case (mode)
          SINK_OPEN:    m_axis_tready <= 1'b1;
          SINK_PATTERN: m_axis_tready <= pattern[phase % 8];
          SINK_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:      m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_acia_serial_port_model: done, errors");
    $finish;
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    holds_asked = 0;
    burst_left = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, countdown starts expired
    offer_request(FUNC_READ, SelCtrl, 8'h00, 8'h00, 1'b0, 8'h00);
    offer_request(FUNC_READ, SelData, 8'h00, 8'h00, 1'b0, 8'h00);
    offer_request(FUNC_WRITE, SelCtrl, 8'ha0, 8'h00, 1'b0, 8'h00);
    offer_request(FUNC_WRITE, SelData, 8'hff, 8'h00, 1'b0, 8'h00);
    offer_request(FUNC_TICK, SelCtrl, 8'h00, 8'h00, 1'b1, 8'hff);
    offer_request(FUNC_TICK, SelData, 8'hff, 8'hff, 1'b1, 8'h00);
    offer_request(FUNC_READ, SelCtrl, 8'h00, 8'h00, 1'b0, 8'h00);
    offer_request(FUNC_READ, SelData, 8'h00, 8'h00, 1'b0, 8'h00);
    offer_request(FuncSpare, SelData, 8'hff, 8'hff, 1'b1, 8'hff);
    offer_request(FUNC_WRITE, SelData, 8'h00, 8'h00, 1'b0, 8'h00);
    // count down the full period with the largest steps
    repeat (5) offer_request(FUNC_TICK, SelCtrl, 8'h00, 8'hff, 1'b0, 8'h00);
    drain_results();

    // zero period, silent line, overrun
    program_port('0, IrqNone, 1'b1);
    offer_request(FUNC_WRITE, SelCtrl, 8'he0, 8'h00, 1'b0, 8'h00);
    offer_request(FUNC_WRITE, SelData, 8'h55, 8'h00, 1'b0, 8'h00);
    offer_request(FUNC_TICK, SelCtrl, 8'h00, 8'h00, 1'b1, 8'haa);
    offer_request(FUNC_TICK, SelCtrl, 8'h00, 8'h00, 1'b1, 8'h5a);
    offer_request(FUNC_READ, SelData, 8'h00, 8'h00, 1'b0, 8'h00);
    offer_request(FUNC_WRITE, SelCtrl, 8'h40, 8'h00, 1'b0, 8'h00);
    offer_request(FUNC_WRITE, SelData, 8'h01, 8'h00, 1'b0, 8'h00);
    offer_request(FUNC_TICK, SelCtrl, 8'h00, 8'h00, 1'b0, 8'h00);
    repeat (180) offer_random_request();
    drain_results();

    program_port(20'd3, 2'd0, 1'b0);
    repeat (280) offer_random_request();
    drain_results();

    program_port(PeriodW'($urandom_range(1, 600)), IrqKindReset, 1'b0);
    for (int i = 0; i < 380; i++) begin
      if (i == 100) holds_asked <= holds_asked + 1;
      offer_random_request();
    end
    drain_results();

    program_port(20'd1, 2'd2, 1'b0);
    repeat (180) offer_random_request();
    drain_results();

    program_port(PeriodW'($urandom_range(1, 50)), 2'($urandom_range(0, 3)), 1'b0);
    repeat (280) offer_random_request();
    drain_results();

    // longest period last, at most one of its ticks can serve
    program_port(PeriodMax, 2'd2, 1'b0);
    repeat (40) offer_random_request();
    drain_results();

    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb_acia_serial_port_model: done, clean");
    end else begin
      $display("tb_acia_serial_port_model: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/acia_pkg.sv
rtl/core/acia_in_stage.sv
rtl/core/acia_core.sv
rtl/core/acia_serial_port_model.sv
tb/acia_port_checker.sv
tb/tb_acia_serial_port_model.sv
